// ===== design/latency_scale_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// latency scale classifier assertion macros
// shared assertion wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef LATENCY_SCALE_CLASSIFIER_MACROS_SVH
`define LATENCY_SCALE_CLASSIFIER_MACROS_SVH

// generic clocked assertion with active-low reset
`define LSC_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the default clock and reset names
`define LSC_ASSERT(label, prop, msg) \
  `LSC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== design/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg
// types, codes and constants shared by the latency scale classifier
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

  localparam int FUNC_W = 2;
  localparam int VAL_W  = 25;
  localparam int THR_W  = 26;
  localparam int SYM_W  = 7;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR    = 2'd0,
    FUNC_ADD      = 2'd1,
    FUNC_BUILD    = 2'd2,
    FUNC_CLASSIFY = 2'd3
  } func_e;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [THR_W-1:0] thr_t;
  typedef logic [SYM_W-1:0]        sym_t;

  localparam val_t WIN_MIN_RESET = 25'sd1000000;
  localparam val_t WIN_MAX_RESET = -25'sd1;
  localparam val_t VAL_NOT_SENT  = -25'sd2;
  localparam val_t VAL_LOST      = -25'sd1;

  localparam sym_t SYM_SPACE = 7'h20;
  localparam sym_t SYM_QUERY = 7'h3F;
  localparam sym_t SYM_DOT   = 7'h2E;
  localparam sym_t SYM_GT    = 7'h3E;
  localparam sym_t SYM_ZERO  = 7'h30;
  localparam sym_t SYM_LC_A  = 7'h61;

  typedef struct packed {
    logic load_item;
    logic div_step;
    logic build_step;
    logic scan_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  direct;
    logic  div_last;
    logic  build_last;
    logic  scan_hit;
  } status_t;

  // display symbol of a graded level
  function automatic sym_t level_symbol(input int lvl, input int levels);
    int split;
    split = (levels - 2) >> 1;
    if (split > 9) begin
      split = 9;
    end
    if (lvl <= 0) begin
      return SYM_DOT;
    end else if (lvl >= levels - 1) begin
      return SYM_GT;
    end else if (lvl <= split) begin
      return SYM_W'(int'(SYM_ZERO) + lvl);
    end else begin
      return SYM_W'(int'(SYM_LC_A) + lvl - split - 1);
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/lsc_if.sv =====
// ----------------------------------------------------------------------------
// lsc channel interfaces
// valid/ready channels for items, results and the configuration register
// ----------------------------------------------------------------------------
`default_nettype none

interface lsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [lsc_pkg::FUNC_W-1:0]  func;
  logic signed [lsc_pkg::VAL_W-1:0] value;
  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface lsc_out_if;
  logic                       valid;
  logic                       ready;
  logic [lsc_pkg::SYM_W-1:0]  symbol;
  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface lsc_cfg_if;
  logic valid;
  logic ready;
  logic presence_only;
  modport source (output valid, output presence_only, input ready);
  modport sink   (input valid, input presence_only, output ready);
endinterface

`default_nettype wire

// ===== design/lsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsc_ctrl
// sequencer for window updates, threshold build, classify walk and output
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output lsc_pkg::cmd_t         cmd_o,
  input  wire lsc_pkg::status_t st_i
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_BUILD = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load_item  = in_fire;
    cmd_o.div_step   = (state_q == ST_DIV);
    cmd_o.build_step = (state_q == ST_BUILD);
    cmd_o.scan_step  = (state_q == ST_SCAN);
    cmd_o.out_load   = (state_q == ST_EMIT) && out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (st_i.func)
            lsc_pkg::FUNC_BUILD:    state_d = ST_DIV;
            lsc_pkg::FUNC_CLASSIFY: state_d = st_i.direct ? ST_EMIT : ST_SCAN;
            default:                state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (st_i.div_last) begin
          state_d = ST_BUILD;
        end
      end
      ST_BUILD: begin
        if (st_i.build_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (st_i.scan_hit) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/lsc_datapath.sv =====
// ----------------------------------------------------------------------------
// lsc_datapath
// latency window, reciprocal range divider, threshold accumulator and compare
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_datapath #(
  parameter int LEVELS = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire lsc_pkg::cmd_t                    cmd_i,
  output lsc_pkg::status_t                      st_o,
  input  wire logic [lsc_pkg::FUNC_W-1:0]       func_i,
  input  wire logic signed [lsc_pkg::VAL_W-1:0] value_i,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_presence_i,
  output logic [lsc_pkg::SYM_W-1:0]             symbol_o
);

  localparam int THR_W = lsc_pkg::THR_W;
  localparam int VAL_W = lsc_pkg::VAL_W;
  localparam int LW    = $clog2(LEVELS);
  localparam int KW    = LW + 1;
  localparam int DEN_I = LEVELS * LEVELS;
  localparam int RW    = $clog2(DEN_I);
  localparam int QS    = THR_W;
  localparam int RECIP_I = (1 << QS) / DEN_I;

  localparam logic [RW:0]      DEN      = (RW+1)'(DEN_I);
  localparam logic [THR_W-1:0] DEN_W    = THR_W'(DEN_I);
  localparam logic [THR_W-1:0] RECIP    = THR_W'(RECIP_I);
  localparam logic [LW-1:0]    LAST_LVL = LW'(LEVELS - 1);
  localparam logic [LW-1:0]    PRES_LVL = LW'(LEVELS - 2);
  localparam logic [1:0]       DIV_END  = 2'd2;

  lsc_pkg::func_e func;

  // window and configuration
  logic          presence_q;
  lsc_pkg::val_t win_min_q;
  lsc_pkg::val_t win_max_q;
  lsc_pkg::thr_t thr_q [LEVELS];

  // item, divider, accumulator and symbol registers
  lsc_pkg::val_t  val_q;
  logic [THR_W-1:0] mag_q;
  logic [THR_W-1:0] quo_q;
  logic [RW-1:0]  drem_q;
  logic           neg_q;
  logic [1:0]     dcnt_q;
  lsc_pkg::thr_t  step_qq;
  logic [RW-1:0]  step_rq;
  lsc_pkg::thr_t  acc_q;
  logic [RW-1:0]  acc_r_q;
  logic [LW-1:0]  idx_q;
  logic [KW-1:0]  k_q;
  lsc_pkg::sym_t  sym_q;
  lsc_pkg::sym_t  out_sym_q;

  lsc_pkg::thr_t    in_ext;
  lsc_pkg::thr_t    vq_ext;
  lsc_pkg::thr_t    range;
  logic [THR_W-1:0] range_mag;
  logic [2*THR_W-1:0] prod;
  logic [THR_W-1:0] quo_est;
  logic [THR_W-1:0] rem_raw;
  logic             rem_ge;
  logic             div_last;
  lsc_pkg::thr_t    step_q_n;
  logic [RW-1:0]    step_r_n;
  logic [RW:0]      sum_r;
  logic             carry;
  logic [RW-1:0]    acc_r_n;
  lsc_pkg::thr_t    acc_n;
  lsc_pkg::thr_t    thr_n;
  logic             lvl_end;
  logic             scan_hit;
  logic             is_not_sent;
  logic             is_lost;
  lsc_pkg::sym_t    sym_direct;

  assign func   = lsc_pkg::func_e'(func_i);
  assign in_ext = {value_i[VAL_W-1], value_i};
  assign vq_ext = {val_q[VAL_W-1], val_q};

  // range of the window, split into sign and magnitude for the divider
  assign range     = {win_max_q[VAL_W-1], win_max_q} - {win_min_q[VAL_W-1], win_min_q};
  assign range_mag = range[THR_W-1] ? THR_W'(-range) : THR_W'(range);

  // divide by levels squared: reciprocal estimate is exact or one low
  assign prod     = {{THR_W{1'b0}}, mag_q} * {{THR_W{1'b0}}, RECIP};
  assign quo_est  = prod[QS +: THR_W];
  assign rem_raw  = mag_q - quo_q * DEN_W;
  assign rem_ge   = (rem_raw >= DEN_W);
  assign div_last = (dcnt_q == DIV_END);

  // floor quotient and remainder of a negative range
  always_comb begin
    if (!neg_q) begin
      step_q_n = quo_q;
      step_r_n = drem_q;
    end else if (drem_q != '0) begin
      step_q_n = ~quo_q;
      step_r_n = RW'(DEN - {1'b0, drem_q});
    end else begin
      step_q_n = THR_W'(-quo_q);
      step_r_n = '0;
    end
  end

  // accumulate range/(LEVELS*LEVELS) per step as quotient plus remainder
  assign sum_r   = {1'b0, acc_r_q} + {1'b0, step_rq};
  assign carry   = (sum_r >= DEN);
  assign acc_r_n = carry ? RW'(sum_r - DEN) : sum_r[RW-1:0];
  assign acc_n   = acc_q + step_qq + {{(THR_W-1){1'b0}}, carry};
  // floor to truncation toward zero
  assign thr_n   = acc_n + {{(THR_W-1){1'b0}}, (acc_n[THR_W-1] && (acc_r_n != '0))};
  assign lvl_end = (k_q == {idx_q, 1'b0});

  assign scan_hit = (vq_ext <= thr_q[idx_q]) || (idx_q == LAST_LVL);

  assign is_not_sent = (value_i == lsc_pkg::VAL_NOT_SENT);
  assign is_lost     = (value_i == lsc_pkg::VAL_LOST);

  always_comb begin
    if (is_not_sent) begin
      sym_direct = lsc_pkg::SYM_SPACE;
    end else if (is_lost) begin
      sym_direct = lsc_pkg::SYM_QUERY;
    end else if (in_ext > thr_q[PRES_LVL]) begin
      sym_direct = lsc_pkg::SYM_GT;
    end else begin
      sym_direct = lsc_pkg::SYM_DOT;
    end
  end

  always_comb begin
    st_o            = '0;
    st_o.func       = func;
    st_o.direct     = is_not_sent || is_lost || presence_q;
    st_o.div_last   = div_last;
    st_o.build_last = lvl_end && (idx_q == LAST_LVL);
    st_o.scan_hit   = scan_hit;
  end

  assign symbol_o = out_sym_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presence_q <= 1'b0;
      win_min_q  <= lsc_pkg::WIN_MIN_RESET;
      win_max_q  <= lsc_pkg::WIN_MAX_RESET;
      for (int i = 0; i < LEVELS; i++) begin
        thr_q[i] <= '0;
      end
      idx_q  <= '0;
      k_q    <= '0;
      dcnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        presence_q <= cfg_presence_i;
      end
      if (cmd_i.load_item) begin
        idx_q  <= '0;
        k_q    <= '0;
        dcnt_q <= '0;
        case (func)
          lsc_pkg::FUNC_CLEAR: begin
            win_min_q <= lsc_pkg::WIN_MIN_RESET;
            win_max_q <= lsc_pkg::WIN_MAX_RESET;
          end
          lsc_pkg::FUNC_ADD: begin
            // negative samples leave the window alone
            if (!value_i[VAL_W-1]) begin
              if (value_i < win_min_q) begin
                win_min_q <= value_i;
              end
              if (value_i > win_max_q) begin
                win_max_q <= value_i;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.div_step && !div_last) begin
        dcnt_q <= dcnt_q + 1'b1;
      end
      if (cmd_i.build_step) begin
        if (lvl_end) begin
          thr_q[idx_q] <= thr_n;
          idx_q        <= idx_q + 1'b1;
          k_q          <= '0;
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
      if (cmd_i.scan_step && !scan_hit) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      val_q <= value_i;
      if (func == lsc_pkg::FUNC_BUILD) begin
        mag_q  <= range_mag;
        drem_q <= '0;
        neg_q  <= range[THR_W-1];
      end
      if (func == lsc_pkg::FUNC_CLASSIFY) begin
        sym_q <= sym_direct;
      end
    end
    if (cmd_i.div_step) begin
      if (dcnt_q == '0) begin
        quo_q <= quo_est;
      end else if (!div_last) begin
        if (rem_ge) begin
          quo_q  <= quo_q + THR_W'(1);
          drem_q <= RW'(rem_raw - DEN_W);
        end else begin
          drem_q <= rem_raw[RW-1:0];
        end
      end else begin
        step_qq <= step_q_n;
        step_rq <= step_r_n;
        acc_q   <= {win_min_q[VAL_W-1], win_min_q};
        acc_r_q <= '0;
      end
    end
    if (cmd_i.build_step) begin
      acc_q   <= acc_n;
      acc_r_q <= acc_r_n;
    end
    if (cmd_i.scan_step && scan_hit) begin
      sym_q <= lsc_pkg::level_symbol(int'(idx_q), LEVELS);
    end
    if (cmd_i.out_load) begin
      out_sym_q <= sym_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/latency_scale_classifier.sv =====
// ----------------------------------------------------------------------------
// latency_scale_classifier
// latency window tracking and display symbol classification
// ----------------------------------------------------------------------------
// Tracks min and max of non-negative latency samples and turns that window
// into LEVELS thresholds growing with the square of the level. One item is
// worked on at a time. Lost, not sent and presence-only values are classified
// directly, others by walking the thresholds, one threshold compared per cycle.
// Build divides the range by LEVELS*LEVELS (reciprocal multiply, then one
// correction step), then makes one accumulator add per unit of (i+1)^2.
// A result sits in an output register, so new items are taken while it waits.
`default_nettype none

module latency_scale_classifier #(
  parameter int LEVELS = 8
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  lsc_in_if.sink    in_i,
  lsc_cfg_if.sink   cfg_i,
  lsc_out_if.source out_o
);

  lsc_pkg::cmd_t    cmd;
  lsc_pkg::status_t st;
  logic             in_ready;
  logic             out_valid;
  logic [lsc_pkg::SYM_W-1:0] symbol;

  assign in_i.ready   = in_ready;
  assign cfg_i.ready  = 1'b1;
  assign out_o.valid  = out_valid;
  assign out_o.symbol = symbol;

  lsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  lsc_datapath #(
    .LEVELS (LEVELS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .func_i         (in_i.func),
    .value_i        (in_i.value),
    .cfg_we_i       (cfg_i.valid),
    .cfg_presence_i (cfg_i.presence_only),
    .symbol_o       (symbol)
  );

endmodule

`default_nettype wire

// ===== design/lsc_checker.sv =====
// ----------------------------------------------------------------------------
// lsc_checker
// port-level checks of the latency scale classifier, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "latency_scale_classifier_macros.svh"

module lsc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic [lsc_pkg::FUNC_W-1:0]  in_func_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [lsc_pkg::SYM_W-1:0]   out_symbol_i
);

  logic in_xfer;
  logic is_classify;

  assign in_xfer     = in_valid_i && in_ready_i;
  assign is_classify = (in_func_i == lsc_pkg::FUNC_CLASSIFY);

  // a classify keeps the block busy for at least the next cycle
  `LSC_ASSERT(a_classify_busy, (in_xfer && is_classify) |=> !in_ready_i, "classify did not stall input")

  // other commands never produce a result
  `LSC_ASSERT(a_no_spurious_out, (in_xfer && !is_classify && !out_valid_i) |=> !out_valid_i, "result without classify")

  `LSC_ASSERT(a_out_hold, (out_valid_i && !out_ready_i) |=> out_valid_i, "result dropped while stalled")

  `LSC_ASSERT(a_out_stable, (out_valid_i && !out_ready_i) |=> $stable(out_symbol_i), "result changed while stalled")

endmodule

bind latency_scale_classifier lsc_checker u_lsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_func_i    (in_i.func),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_symbol_i (out_o.symbol)
);

`default_nettype wire

// ===== sim/tb_latency_scale_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_latency_scale_classifier
// self-checking bench: window tracking, threshold builds and symbol lookup
// ----------------------------------------------------------------------------
// Clear, add and build items update a local copy of the latency window and the
// threshold table. Classify items queue the symbol they should produce, and
// each symbol that leaves the block is compared against the oldest entry.
// Directed items cover the reset table, the empty window, the field extremes
// and both display modes. They are followed by random windows: clear, a few
// samples at mixed scales, build, then probes placed around the thresholds.
// Both sides stall at random.
`default_nettype none

module tb_latency_scale_classifier;

  localparam int LEVELS      = 8;
  localparam int DEN         = LEVELS * LEVELS;
  localparam int SETTLE      = 28 + LEVELS * LEVELS + 16;
  localparam int STALL_LIMIT = 4000;
  localparam int ITEM_TARGET = 1950;
  localparam int LONG_HOLD   = 400;
  localparam int VAL_MAX     = 16777215;
  localparam int VAL_MIN     = -16777216;

  logic clk_i;
  logic rst_ni;

  lsc_in_if  in_if ();
  lsc_out_if out_if ();
  lsc_cfg_if cfg_if ();

  latency_scale_classifier #(.LEVELS(LEVELS)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // local copy of the block state
  bit   presence_mode;
  int   win_lo;
  int   win_hi;
  int   thr [LEVELS];
  lsc_pkg::sym_t expected_symbols [$];

  int   items_sent;
  int   symbols_checked;
  int   builds_done;
  int   mode_writes;
  int   fail_count;
  int   quiet_cycles;
  bit   steady;
  int   hold_request;
  lsc_pkg::sym_t want;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // graded scale: dot, digits, letters, then '>' on the top level
  function automatic lsc_pkg::sym_t grade_symbol(int lvl);
    int digits;
    digits = (LEVELS - 2) / 2;
    if (digits > 9) digits = 9;
    if (lvl == 0) return lsc_pkg::SYM_DOT;
    if (lvl == LEVELS - 1) return lsc_pkg::SYM_GT;
    if (lvl <= digits) return lsc_pkg::sym_t'(int'(lsc_pkg::SYM_ZERO) + lvl);
    return lsc_pkg::sym_t'(int'(lsc_pkg::SYM_LC_A) + (lvl - digits - 1));
  endfunction

  function automatic lsc_pkg::sym_t classify_symbol(lsc_pkg::val_t v);
    int x;
    x = int'(v);
    if (v == lsc_pkg::VAL_NOT_SENT) return lsc_pkg::SYM_SPACE;
    if (v == lsc_pkg::VAL_LOST) return lsc_pkg::SYM_QUERY;
    if (presence_mode) return (x > thr[LEVELS-2]) ? lsc_pkg::SYM_GT : lsc_pkg::SYM_DOT;
    for (int i = 0; i < LEVELS; i++) begin
      if (x <= thr[i]) return grade_symbol(i);
    end
    return lsc_pkg::SYM_GT;
  endfunction

  // thresholds grow with the square of the level, truncated toward zero
  task automatic build_levels();
    longint span;
    longint acc;
    span = longint'(win_hi) - longint'(win_lo);
    for (int i = 0; i < LEVELS; i++) begin
      acc = longint'(win_lo) * DEN + span * (i + 1) * (i + 1);
      thr[i] = int'(acc / DEN);
    end
  endtask

  task automatic track_item(lsc_pkg::func_e f, lsc_pkg::val_t v);
    int x;
    x = int'(v);
    case (f)
      lsc_pkg::FUNC_CLEAR: begin
        win_lo = int'(lsc_pkg::WIN_MIN_RESET);
        win_hi = int'(lsc_pkg::WIN_MAX_RESET);
      end
      lsc_pkg::FUNC_ADD: begin
        if (x >= 0) begin
          if (x < win_lo) win_lo = x;
          if (x > win_hi) win_hi = x;
        end
      end
      lsc_pkg::FUNC_BUILD: begin
        build_levels();
        builds_done++;
      end
      default: begin
        expected_symbols.push_back(classify_symbol(v));
      end
    endcase
  endtask

  // valid stays high after a transfer so back-to-back items need no toggle
  task automatic send_item(lsc_pkg::func_e f, lsc_pkg::val_t v);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.func  <= f;
    in_if.value <= v;
    do @(posedge clk_i); while (!in_if.ready);
    track_item(f, v);
    items_sent++;
  endtask

  // no item can be in flight once this returns
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_presence(bit m);
    wait_idle();
    cfg_if.valid         <= 1'b1;
    cfg_if.presence_only <= m;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    presence_mode = m;
    mode_writes++;
  endtask

  task automatic log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  function automatic lsc_pkg::val_t sample_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return lsc_pkg::val_t'(0 - int'($urandom_range(1, 16777216)));
    if (r < 40) return lsc_pkg::val_t'($urandom_range(0, 63));
    if (r < 65) return lsc_pkg::val_t'($urandom_range(0, 5000));
    if (r < 80) return lsc_pkg::val_t'($urandom_range(999990, 1000010));
    return lsc_pkg::val_t'($urandom_range(0, VAL_MAX));
  endfunction

  // probes land mostly right around a threshold
  function automatic lsc_pkg::val_t probe_value();
    int r;
    int x;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      x = thr[$urandom_range(0, LEVELS - 1)] + int'($urandom_range(0, 4)) - 2;
      if (x > VAL_MAX) x = VAL_MAX;
      return lsc_pkg::val_t'(x);
    end
    if (r < 65) begin
      return ($urandom_range(0, 1) != 0) ? lsc_pkg::VAL_LOST : lsc_pkg::VAL_NOT_SENT;
    end
    if (r < 72) return lsc_pkg::val_t'(0 - int'($urandom_range(3, 16777216)));
    if (r < 85) begin
      if (win_lo <= win_hi) return lsc_pkg::val_t'($urandom_range(win_hi, win_lo));
      return lsc_pkg::val_t'($urandom_range(0, 1000));
    end
    return lsc_pkg::val_t'($urandom_range(0, VAL_MAX));
  endfunction

  // result side: random hold-offs, or a long one on request
  initial begin : result_sink
    int n;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else if (steady) begin
        n = 0;
      end else begin
        n = pick_gap();
      end
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        symbols_checked++;
        if (expected_symbols.size() == 0) begin
          log_failure($sformatf("unexpected symbol 0x%02h with nothing pending",
                                out_if.symbol));
        end else begin
          want = expected_symbols.pop_front();
          if (out_if.symbol !== want) begin
            log_failure($sformatf("symbol mismatch: expected 0x%02h '%c' got 0x%02h '%c'",
                                  want, want, out_if.symbol, out_if.symbol));
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d symbols pending",
                 quiet_cycles, expected_symbols.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // reset table is all zero; then a build from the empty window
  task automatic test_reset_window();
    send_item(lsc_pkg::FUNC_CLASSIFY, lsc_pkg::VAL_NOT_SENT);
    send_item(lsc_pkg::FUNC_CLASSIFY, lsc_pkg::VAL_LOST);
    send_item(lsc_pkg::FUNC_CLASSIFY, lsc_pkg::val_t'(0));
    send_item(lsc_pkg::FUNC_CLASSIFY, lsc_pkg::val_t'(1));
    send_item(lsc_pkg::FUNC_CLASSIFY, lsc_pkg::val_t'(VAL_MIN));
    send_item(lsc_pkg::FUNC_BUILD, lsc_pkg::val_t'(0));
    send_item(lsc_pkg::FUNC_CLASSIFY, lsc_pkg::val_t'(0));
    send_item(lsc_pkg::FUNC_CLASSIFY, lsc_pkg::val_t'(VAL_MAX));
  endtask

  // widest window, negative sample ignored, probes exactly on each threshold but the top one
  task automatic test_window_extremes();
    send_item(lsc_pkg::FUNC_CLEAR, lsc_pkg::val_t'(VAL_MAX));
    send_item(lsc_pkg::FUNC_ADD, lsc_pkg::val_t'(VAL_MIN));
    send_item(lsc_pkg::FUNC_ADD, lsc_pkg::val_t'(0));
    send_item(lsc_pkg::FUNC_ADD, lsc_pkg::val_t'(VAL_MAX));
    send_item(lsc_pkg::FUNC_BUILD, lsc_pkg::val_t'(VAL_MIN));
    for (int i = 0; i < LEVELS - 1; i++) begin
      send_item(lsc_pkg::FUNC_CLASSIFY, lsc_pkg::val_t'(thr[i]));
    end
  endtask

  task automatic test_presence_mode();
    write_presence(1'b1);
    send_item(lsc_pkg::FUNC_CLASSIFY, lsc_pkg::val_t'(thr[LEVELS-2]));
    send_item(lsc_pkg::FUNC_CLASSIFY, lsc_pkg::val_t'(thr[LEVELS-2] + 1));
    send_item(lsc_pkg::FUNC_CLASSIFY, lsc_pkg::VAL_LOST);
    send_item(lsc_pkg::FUNC_CLASSIFY, lsc_pkg::VAL_NOT_SENT);
    send_item(lsc_pkg::FUNC_CLASSIFY, lsc_pkg::val_t'(VAL_MIN));
    write_presence(1'b0);
  endtask

  // result side holds off long enough for the input to back up
  task automatic test_backpressure();
    steady = 1'b1;
    hold_request = LONG_HOLD;
    repeat (24) send_item(lsc_pkg::FUNC_CLASSIFY, probe_value());
    steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    send_item(lsc_pkg::FUNC_CLEAR, lsc_pkg::val_t'(0));
    repeat (3) send_item(lsc_pkg::FUNC_ADD, sample_value());
    send_item(lsc_pkg::FUNC_BUILD, lsc_pkg::val_t'(0));
    repeat (8) send_item(lsc_pkg::FUNC_CLASSIFY, probe_value());
    in_if.valid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk_i);
    repeat (6) send_item(lsc_pkg::FUNC_CLASSIFY, probe_value());
  endtask

  task automatic test_random_windows();
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 8) write_presence(1'($urandom_range(0, 1)));
      steady = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // raw noise, any command and any value
        repeat ($urandom_range(1, 6)) begin
          send_item(lsc_pkg::func_e'($urandom_range(0, 3)), lsc_pkg::val_t'($urandom));
        end
      end else begin
        if ($urandom_range(0, 9) != 0) send_item(lsc_pkg::FUNC_CLEAR, lsc_pkg::val_t'($urandom));
        repeat ($urandom_range(1, 6)) send_item(lsc_pkg::FUNC_ADD, sample_value());
        // now and then skip the build so probes hit a stale table
        if ($urandom_range(0, 9) != 0) send_item(lsc_pkg::FUNC_BUILD, lsc_pkg::val_t'($urandom));
        repeat ($urandom_range(4, 24)) send_item(lsc_pkg::FUNC_CLASSIFY, probe_value());
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.func           <= lsc_pkg::FUNC_CLEAR;
    in_if.value          <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.presence_only <= 1'b0;
    presence_mode = 1'b0;
    win_lo        = int'(lsc_pkg::WIN_MIN_RESET);
    win_hi        = int'(lsc_pkg::WIN_MAX_RESET);
    for (int i = 0; i < LEVELS; i++) thr[i] = 0;
    steady        = 1'b0;
    hold_request  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_window();
    test_window_extremes();
    test_presence_mode();
    test_backpressure();
    test_drain_pause();
    test_random_windows();

    wait_idle();
    if (expected_symbols.size() != 0) begin
      log_failure($sformatf("%0d symbols never arrived", expected_symbols.size()));
    end
    $display("covered %0d items with %0d threshold builds and %0d mode writes",
             items_sent, builds_done, mode_writes);
    $display("checked %0d symbols, %0d failures", symbols_checked, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/lsc_pkg.sv
design/lsc_if.sv
design/lsc_ctrl.sv
design/lsc_datapath.sv
design/latency_scale_classifier.sv
design/lsc_checker.sv
sim/tb_latency_scale_classifier.sv
